>>> rtl/core/gpio_irq_pkg.sv
// ----------------------------------------------------------------------------
// gpio_irq_pkg
// types and constants shared by the gpio port with interrupts
// ----------------------------------------------------------------------------
package gpio_irq_pkg;

  localparam int unsigned DATA_W         = 8;
  localparam int unsigned MAX_PORT_WIDTH = 32;
  localparam int unsigned PORT_WIDTH_DEF = 8;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    SEL_DATA   = 4'd0,
    SEL_DIR    = 4'd1,
    SEL_SENSE  = 4'd2,
    SEL_BOTH   = 4'd3,
    SEL_EVENT  = 4'd4,
    SEL_MASK   = 4'd5,
    SEL_RAW    = 4'd6,
    SEL_MASKED = 4'd7,
    SEL_CLEAR  = 4'd8
  } sel_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [3:0]        reg_select;
    logic [DATA_W-1:0] data_mask;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] pin_levels;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] pad_out;
    logic [DATA_W-1:0] pad_enable;
    logic              irq;
  } rsp_t;

endpackage

>>> rtl/core/gpio_irq_regfile.sv
// ----------------------------------------------------------------------------
// gpio_irq_regfile
// port registers, edge latches and read mux; gives the beat for one request
// ----------------------------------------------------------------------------
module gpio_irq_regfile #(
  parameter int unsigned PORT_WIDTH = gpio_irq_pkg::PORT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  gpio_irq_pkg::req_t req,
  output gpio_irq_pkg::rsp_t rsp_next
);

  localparam int unsigned MaxW = gpio_irq_pkg::MAX_PORT_WIDTH;
  localparam int unsigned DW   = gpio_irq_pkg::DATA_W;

  logic [PORT_WIDTH-1:0] out_data, direction, sense_level, both_edges;
  logic [PORT_WIDTH-1:0] event_high, int_mask, raw_status, last_pins;

  logic [PORT_WIDTH-1:0] out_data_next, direction_next, sense_level_next, both_edges_next;
  logic [PORT_WIDTH-1:0] event_high_next, int_mask_next, raw_status_next, last_pins_next;

  logic [MaxW-1:0]       dmask_w, wd_w, pins_w, rd_w, pad_out_w, pad_en_w;
  logic [PORT_WIDTH-1:0] dmask, wd, pins, rd;
  logic [PORT_WIDTH-1:0] raw_now, raw_now_next, rise, fall, ev;

  assign dmask_w = MaxW'(req.data_mask);
  assign wd_w    = MaxW'(req.write_data);
  assign pins_w  = MaxW'(req.pin_levels);
  assign dmask   = dmask_w[PORT_WIDTH-1:0];
  assign wd      = wd_w[PORT_WIDTH-1:0];
  assign pins    = pins_w[PORT_WIDTH-1:0];

  assign raw_now = (raw_status & ~sense_level) |
                   (~(last_pins ^ event_high) & sense_level);

  assign rise = ~last_pins & pins;
  assign fall = last_pins & ~pins;
  assign ev   = (both_edges & (rise | fall)) |
                (~both_edges & ((rise & event_high) | (fall & ~event_high)));

  always_comb begin
    out_data_next    = out_data;
    direction_next   = direction;
    sense_level_next = sense_level;
    both_edges_next  = both_edges;
    event_high_next  = event_high;
    int_mask_next    = int_mask;
    raw_status_next  = raw_status;
    last_pins_next   = last_pins;
    rd               = '0;
    unique case (gpio_irq_pkg::op_t'(req.op))
      gpio_irq_pkg::OP_READ: begin
        case (gpio_irq_pkg::sel_t'(req.reg_select))
          gpio_irq_pkg::SEL_DATA:
            rd = ((out_data & direction) | (last_pins & ~direction)) & dmask;
          gpio_irq_pkg::SEL_DIR:    rd = direction;
          gpio_irq_pkg::SEL_SENSE:  rd = sense_level;
          gpio_irq_pkg::SEL_BOTH:   rd = both_edges;
          gpio_irq_pkg::SEL_EVENT:  rd = event_high;
          gpio_irq_pkg::SEL_MASK:   rd = int_mask;
          gpio_irq_pkg::SEL_RAW:    rd = raw_now;
          gpio_irq_pkg::SEL_MASKED: rd = raw_now & int_mask;
          default:                  rd = '0;
        endcase
      end
      gpio_irq_pkg::OP_WRITE: begin
        case (gpio_irq_pkg::sel_t'(req.reg_select))
          gpio_irq_pkg::SEL_DATA:  out_data_next = (out_data & ~dmask) | (wd & dmask);
          gpio_irq_pkg::SEL_DIR:   direction_next = wd;
          gpio_irq_pkg::SEL_SENSE: begin
            sense_level_next = wd;
            raw_status_next  = raw_status & ~wd;
          end
          gpio_irq_pkg::SEL_BOTH:  both_edges_next = wd;
          gpio_irq_pkg::SEL_EVENT: event_high_next = wd;
          gpio_irq_pkg::SEL_MASK:  int_mask_next = wd;
          gpio_irq_pkg::SEL_CLEAR: raw_status_next = raw_status & ~wd;
          default: ;
        endcase
      end
      gpio_irq_pkg::OP_TICK: begin
        raw_status_next = (raw_status | ev) & ~sense_level;
        last_pins_next  = pins;
      end
      gpio_irq_pkg::OP_NONE: ;
    endcase
  end

  assign raw_now_next = (raw_status_next & ~sense_level_next) |
                        (~(last_pins_next ^ event_high_next) & sense_level_next);

  assign rd_w      = MaxW'(rd);
  assign pad_out_w = MaxW'(out_data_next);
  assign pad_en_w  = MaxW'(direction_next);

  assign rsp_next.read_data  = rd_w[DW-1:0];
  assign rsp_next.pad_out    = pad_out_w[DW-1:0];
  assign rsp_next.pad_enable = pad_en_w[DW-1:0];
  assign rsp_next.irq        = |(raw_now_next & int_mask_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_data    <= '0;
      direction   <= '0;
      sense_level <= '0;
      both_edges  <= '0;
      event_high  <= '0;
      int_mask    <= '0;
      raw_status  <= '0;
      last_pins   <= '0;
    end else if (en) begin
      out_data    <= out_data_next;
      direction   <= direction_next;
      sense_level <= sense_level_next;
      both_edges  <= both_edges_next;
      event_high  <= event_high_next;
      int_mask    <= int_mask_next;
      raw_status  <= raw_status_next;
      last_pins   <= last_pins_next;
    end
  end

`ifndef SYNTHESIS
  a_no_latch_on_level: assert property (@(posedge clk) disable iff (rst)
    (raw_status & sense_level) == '0)
    else $error("edge latch set on a level-sensed pin");

  a_tick_samples: assert property (@(posedge clk) disable iff (rst)
    (en && (req.op == gpio_irq_pkg::OP_TICK)) |=> (last_pins == $past(pins)))
    else $error("tick did not capture pin levels");

  a_read_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (en && (req.op == gpio_irq_pkg::OP_READ)) |=>
      ($stable(out_data) && $stable(direction) && $stable(raw_status)
       && $stable(last_pins)))
    else $error("read changed port state");
`endif

endmodule

>>> rtl/core/gpio_port_with_interrupts_top.sv
// a request beat passes the request register, then the result register, before its response beat
// throughput: one request per cycle while the response side keeps up
// a stalled response lets the request register take one more beat, then req_ready drops
// reset: synchronous, clears every port register, edge latch and pin history to zero
// ----------------------------------------------------------------------------
// gpio_port_with_interrupts_top
// gpio port with masked data access and edge or level interrupts
// ----------------------------------------------------------------------------
module gpio_port_with_interrupts_top #(
  parameter int unsigned PORT_WIDTH = gpio_irq_pkg::PORT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  gpio_irq_pkg::req_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output gpio_irq_pkg::rsp_t rsp
);

  logic               s1_valid;
  gpio_irq_pkg::req_t s1_req;
  logic               advance;
  gpio_irq_pkg::rsp_t rsp_next;

  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_req <= req;
    end
  end

  gpio_irq_regfile #(
    .PORT_WIDTH(PORT_WIDTH)
  ) u_regfile (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .req      (s1_req),
    .rsp_next (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the gpio port with interrupts against a cycle-free behavioral
// predictor: directed register, data-mask and interrupt cases first, then
// random register traffic and pin ticks under sender gaps, receiver stalls
// and one long output hold-off that must back up the request side
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] SEL_UNUSED_LO = 4'd9;
  localparam logic [3:0] SEL_UNUSED_HI = 4'd15;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  gpio_irq_pkg::req_t req       = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  gpio_irq_pkg::rsp_t rsp;

  gpio_port_with_interrupts_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted port state
  logic [7:0] out_q;
  logic [7:0] dir_q;
  logic [7:0] sense_q;
  logic [7:0] both_q;
  logic [7:0] evt_q;
  logic [7:0] imask_q;
  logic [7:0] latch_q;
  logic [7:0] pins_q;

  gpio_irq_pkg::rsp_t pending_rsp[$];
  int unsigned errors       = 0;
  int unsigned beats_in     = 0;
  int unsigned beats_out    = 0;
  int unsigned ticks_in     = 0;
  int unsigned irq_seen     = 0;
  int unsigned input_stalls = 0;
  int unsigned cycles       = 0;

  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned hold_asks     = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_cnt      = 0;
  logic [7:0]  gen_pins      = '0;

  initial begin
    out_q   = '0;
    dir_q   = '0;
    sense_q = '0;
    both_q  = '0;
    evt_q   = '0;
    imask_q = '0;
    latch_q = '0;
    pins_q  = '0;
  end

  function automatic logic [7:0] status_now();
    logic [7:0] lvl;
    lvl = (pins_q & evt_q) | (~pins_q & ~evt_q);
    return (latch_q & ~sense_q) | (lvl & sense_q);
  endfunction

  function automatic gpio_irq_pkg::rsp_t gpio_predict(gpio_irq_pkg::req_t r);
    logic [7:0]         rd;
    logic [7:0]         rise;
    logic [7:0]         fall;
    logic [7:0]         single;
    logic [7:0]         ev;
    gpio_irq_pkg::rsp_t p;
    rd = '0;
    case (r.op)
      gpio_irq_pkg::OP_READ: begin
        case (r.reg_select)
          gpio_irq_pkg::SEL_DATA:
            rd = ((out_q & dir_q) | (pins_q & ~dir_q)) & r.data_mask;
          gpio_irq_pkg::SEL_DIR:    rd = dir_q;
          gpio_irq_pkg::SEL_SENSE:  rd = sense_q;
          gpio_irq_pkg::SEL_BOTH:   rd = both_q;
          gpio_irq_pkg::SEL_EVENT:  rd = evt_q;
          gpio_irq_pkg::SEL_MASK:   rd = imask_q;
          gpio_irq_pkg::SEL_RAW:    rd = status_now();
          gpio_irq_pkg::SEL_MASKED: rd = status_now() & imask_q;
          default:                  rd = '0;
        endcase
      end
      gpio_irq_pkg::OP_WRITE: begin
        case (r.reg_select)
          gpio_irq_pkg::SEL_DATA:
            out_q = (out_q & ~r.data_mask) | (r.write_data & r.data_mask);
          gpio_irq_pkg::SEL_DIR:   dir_q = r.write_data;
          gpio_irq_pkg::SEL_SENSE: begin
            sense_q = r.write_data;
            latch_q = latch_q & ~r.write_data;
          end
          gpio_irq_pkg::SEL_BOTH:  both_q = r.write_data;
          gpio_irq_pkg::SEL_EVENT: evt_q = r.write_data;
          gpio_irq_pkg::SEL_MASK:  imask_q = r.write_data;
          gpio_irq_pkg::SEL_CLEAR: latch_q = latch_q & ~r.write_data;
          default: ;
        endcase
      end
      gpio_irq_pkg::OP_TICK: begin
        rise    = ~pins_q & r.pin_levels;
        fall    = pins_q & ~r.pin_levels;
        single  = (rise & evt_q) | (fall & ~evt_q);
        ev      = (both_q & (rise | fall)) | (~both_q & single);
        latch_q = (latch_q | ev) & ~sense_q;
        pins_q  = r.pin_levels;
      end
      default: ;
    endcase
    p.read_data  = rd;
    p.pad_out    = out_q;
    p.pad_enable = dir_q;
    p.irq        = |(status_now() & imask_q);
    return p;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want != got) begin
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // scoreboard: check response beats, then queue predictions for request beats
  always @(posedge clk) begin : scoreboard
    gpio_irq_pkg::rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        beats_out++;
        if (rsp.irq) irq_seen++;
        if (pending_rsp.size() == 0) begin
          errors++;
          $display("%0t unexpected response beat: actual %0h", $time, rsp);
        end else begin
          want = pending_rsp.pop_front();
          check_field("read_data", want.read_data, rsp.read_data);
          check_field("pad_out", want.pad_out, rsp.pad_out);
          check_field("pad_enable", want.pad_enable, rsp.pad_enable);
          check_field("irq", {7'd0, want.irq}, {7'd0, rsp.irq});
        end
      end
      if (req_valid && !req_ready) input_stalls++;
      if (req_valid && req_ready) begin
        beats_in++;
        if (req.op == gpio_irq_pkg::OP_TICK) ticks_in++;
        pending_rsp.push_back(gpio_predict(req));
      end
    end
  end

  // response side: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_cnt  <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d responses outstanding", $time, pending_rsp.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_beat(input gpio_irq_pkg::req_t r);
    logic [31:0] junk;
    while ($urandom_range(99) < send_idle_pct) begin
      junk = $urandom;
      req_valid <= 1'b0;
      req       <= junk[$bits(gpio_irq_pkg::req_t)-1:0];
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  function automatic gpio_irq_pkg::req_t make_req(gpio_irq_pkg::op_t op, logic [3:0] sel,
                                                  logic [7:0] dmask, logic [7:0] wdata,
                                                  logic [7:0] pins);
    gpio_irq_pkg::req_t r;
    r.op         = op;
    r.reg_select = sel;
    r.data_mask  = dmask;
    r.write_data = wdata;
    r.pin_levels = pins;
    return r;
  endfunction

  function automatic gpio_irq_pkg::req_t random_req();
    gpio_irq_pkg::req_t r;
    int unsigned        pick;
    r.data_mask  = 8'($urandom_range(255));
    r.write_data = 8'($urandom_range(255));
    pick         = $urandom_range(99);
    if (pick < 38) r.op = gpio_irq_pkg::OP_TICK;
    else if (pick < 72) r.op = gpio_irq_pkg::OP_WRITE;
    else if (pick < 96) r.op = gpio_irq_pkg::OP_READ;
    else r.op = gpio_irq_pkg::OP_NONE;
    if ($urandom_range(11) == 0)
      r.reg_select = 4'($urandom_range(SEL_UNUSED_HI, SEL_UNUSED_LO));
    else if (r.op == gpio_irq_pkg::OP_WRITE && $urandom_range(3) == 0)
      r.reg_select = gpio_irq_pkg::SEL_CLEAR;
    else
      r.reg_select = 4'($urandom_range(gpio_irq_pkg::SEL_CLEAR));
    // pins mostly toggle a bit or two so edge latches do not saturate
    if ($urandom_range(3) == 0) gen_pins = 8'($urandom_range(255));
    else gen_pins = gen_pins ^ (8'd1 << $urandom_range(7)) ^ (8'd1 << $urandom_range(7));
    r.pin_levels = (r.op == gpio_irq_pkg::OP_TICK) ? gen_pins : 8'($urandom_range(255));
    return r;
  endfunction

  task automatic run_random(input int unsigned n);
    repeat (n) send_beat(random_req());
  endtask

  task automatic test_directed();
    send_beat(make_req(gpio_irq_pkg::OP_READ, gpio_irq_pkg::SEL_DATA,
                       8'hFF, 8'h00, 8'h00));
    send_beat(make_req(gpio_irq_pkg::OP_WRITE, gpio_irq_pkg::SEL_DIR,
                       8'h00, 8'h0F, 8'hFF));
    send_beat(make_req(gpio_irq_pkg::OP_WRITE, gpio_irq_pkg::SEL_DATA,
                       8'h3C, 8'hFF, 8'h00));
    send_beat(make_req(gpio_irq_pkg::OP_READ, gpio_irq_pkg::SEL_DATA,
                       8'hFF, 8'h00, 8'hFF));
    send_beat(make_req(gpio_irq_pkg::OP_WRITE, gpio_irq_pkg::SEL_EVENT,
                       8'hFF, 8'hAA, 8'h00));
    send_beat(make_req(gpio_irq_pkg::OP_WRITE, gpio_irq_pkg::SEL_BOTH,
                       8'h00, 8'h0F, 8'h00));
    send_beat(make_req(gpio_irq_pkg::OP_WRITE, gpio_irq_pkg::SEL_MASK,
                       8'h00, 8'hFF, 8'h00));
    send_beat(make_req(gpio_irq_pkg::OP_TICK, gpio_irq_pkg::SEL_CLEAR,
                       8'hFF, 8'hFF, 8'hFF));
    send_beat(make_req(gpio_irq_pkg::OP_TICK, gpio_irq_pkg::SEL_DATA,
                       8'h00, 8'h00, 8'h00));
    send_beat(make_req(gpio_irq_pkg::OP_READ, gpio_irq_pkg::SEL_RAW,
                       8'h00, 8'h00, 8'h00));
    send_beat(make_req(gpio_irq_pkg::OP_READ, gpio_irq_pkg::SEL_MASKED,
                       8'h00, 8'h00, 8'h00));
    send_beat(make_req(gpio_irq_pkg::OP_WRITE, gpio_irq_pkg::SEL_RAW,
                       8'hFF, 8'h00, 8'h00));
    send_beat(make_req(gpio_irq_pkg::OP_WRITE, gpio_irq_pkg::SEL_MASKED,
                       8'hFF, 8'h00, 8'h00));
    send_beat(make_req(gpio_irq_pkg::OP_WRITE, gpio_irq_pkg::SEL_CLEAR,
                       8'h00, 8'h0F, 8'h00));
    send_beat(make_req(gpio_irq_pkg::OP_WRITE, gpio_irq_pkg::SEL_SENSE,
                       8'h00, 8'hC0, 8'h00));
    send_beat(make_req(gpio_irq_pkg::OP_READ, gpio_irq_pkg::SEL_RAW,
                       8'h00, 8'h00, 8'h00));
    send_beat(make_req(gpio_irq_pkg::OP_WRITE, gpio_irq_pkg::SEL_CLEAR,
                       8'h00, 8'hFF, 8'h00));
    send_beat(make_req(gpio_irq_pkg::OP_READ, gpio_irq_pkg::SEL_SENSE,
                       8'hFF, 8'hFF, 8'hFF));
    send_beat(make_req(gpio_irq_pkg::OP_WRITE, gpio_irq_pkg::SEL_MASK,
                       8'hFF, 8'h00, 8'hFF));
    send_beat(make_req(gpio_irq_pkg::OP_NONE, gpio_irq_pkg::SEL_CLEAR,
                       8'hFF, 8'hFF, 8'hFF));
    send_beat(make_req(gpio_irq_pkg::OP_READ, SEL_UNUSED_LO, 8'hFF, 8'hFF, 8'hFF));
    send_beat(make_req(gpio_irq_pkg::OP_WRITE, SEL_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF));
    send_beat(make_req(gpio_irq_pkg::OP_READ, SEL_UNUSED_HI, 8'hFF, 8'h00, 8'h00));
    send_beat(make_req(gpio_irq_pkg::OP_READ, gpio_irq_pkg::SEL_DATA,
                       8'h00, 8'hFF, 8'hFF));
    send_beat(make_req(gpio_irq_pkg::OP_TICK, gpio_irq_pkg::SEL_DIR,
                       8'h5A, 8'hA5, 8'h55));
  endtask

  task automatic test_random_no_gaps();
    send_idle_pct = 0;
    rsp_stall_pct <= 0;
    run_random(140);
  endtask

  task automatic test_random_sender_gaps();
    send_idle_pct = 67;
    rsp_stall_pct <= 0;
    run_random(140);
  endtask

  task automatic test_random_receiver_stalls();
    send_idle_pct = 0;
    rsp_stall_pct <= 67;
    run_random(140);
  endtask

  task automatic test_random_both_gaps();
    send_idle_pct = 29;
    rsp_stall_pct <= 29;
    run_random(110);
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    rsp_stall_pct <= 0;
    hold_asks     <= hold_asks + 1;
    run_random(30);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_no_gaps();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_gaps();
    test_output_backpressure();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d request beats (%0d pin ticks), %0d responses checked",
             beats_in, ticks_in, beats_out);
    $display("irq seen high %0d times, request side held off %0d cycles, %0d errors",
             irq_seen, input_stalls, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> gpio_port_with_interrupts_top.f
rtl/core/gpio_irq_pkg.sv
rtl/core/gpio_irq_regfile.sv
rtl/core/gpio_port_with_interrupts_top.sv
bench/tb.sv
